FILE: src/qked_pkg.sv
// Shared types, constants and the quadrature transition table for the
// knob event decoder. No dependencies.
`timescale 1ns / 1ps

package qked_pkg;

  localparam int HoldW   = 16;
  localparam int DetentW = 3;
  localparam int AccumW  = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 16;

  localparam logic [HoldW-1:0]   LONG_PRESS_RST = 16'd800;
  localparam logic [HoldW-1:0]   RESET_HOLD_RST = 16'd5000;
  localparam logic [DetentW-1:0] DETENT_RST     = 3'd2;
  localparam logic [1:0]         AB_IDLE        = 2'b11;
  localparam logic signed [AccumW:0] ACCUM_MAX  = 9'sd127;
  localparam logic signed [AccumW:0] ACCUM_MIN  = -9'sd127;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS = 2'd0,
    CFG_RESET_HOLD = 2'd1,
    CFG_DETENT     = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CW    = 3'd1,
    EV_CCW   = 3'd2,
    EV_SHORT = 3'd3,
    EV_LONG  = 3'd4,
    EV_RESET = 3'd5
  } event_t;

  // step per {prev_ab, cur_ab}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0,  2'sd1, -2'sd1,  2'sd0,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
     2'sd0, -2'sd1,  2'sd1,  2'sd0
  };

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic key_level;
    logic ms_tick;
  } in_item_t;

  typedef struct packed {
    event_t           event_res;
    logic [HoldW-1:0] hold_ms;
  } out_item_t;

  typedef struct packed {
    logic [HoldW-1:0]   long_limit;
    logic [HoldW-1:0]   reset_hold_ms;
    logic [DetentW-1:0] detent_steps;
  } cfg_t;

  typedef struct packed {
    logic                     key_down;
    logic signed [AccumW-1:0] step_accum;
  } core_status_t;

endpackage

FILE: src/qked_cfg.sv
// Configuration register file for the knob event decoder.
// Depends on qked_pkg.
`timescale 1ns / 1ps

module qked_cfg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [qked_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [qked_pkg::CfgW-1:0]    cfg_data,
  output qked_pkg::cfg_t          cfg
);
  import qked_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_limit    <= LONG_PRESS_RST;
      cfg.reset_hold_ms <= RESET_HOLD_RST;
      cfg.detent_steps  <= DETENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PRESS: cfg.long_limit    <= cfg_data;
        CFG_RESET_HOLD: cfg.reset_hold_ms <= cfg_data;
        CFG_DETENT:     cfg.detent_steps  <= cfg_data[DetentW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/qked_core.sv
// Decoder state and per-item update: transition table, saturating step
// accumulator, detent check, button hold timer. Depends on qked_pkg.
`timescale 1ns / 1ps

module qked_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  qked_pkg::in_item_t  item,
  input  qked_pkg::cfg_t      cfg,
  output qked_pkg::out_item_t result,
  output qked_pkg::core_status_t status
);
  import qked_pkg::*;

  logic [1:0]               prev_ab, prev_ab_next;
  logic signed [AccumW-1:0] step_accum, step_accum_next;
  logic                     key_down, key_down_next;
  logic [HoldW-1:0]         hold_count, hold_count_next;
  logic                     long_fired, long_fired_next;
  logic                     reset_fired, reset_fired_next;

  logic [1:0]               cur_ab;
  logic signed [1:0]        step;
  logic signed [AccumW:0]   sum;
  logic signed [AccumW:0]   sat;
  logic signed [AccumW:0]   det;
  logic [DetentW-1:0]       det_u;
  logic                     pressed;
  logic [HoldW-1:0]         hold_tick;
  event_t                   ev;

  always_comb begin
    cur_ab  = {item.pin_a, item.pin_b};
    pressed = !item.key_level;
    step    = STEP_TABLE[{prev_ab, cur_ab}];
    sum     = $signed({step_accum[AccumW-1], step_accum})
            + $signed({{(AccumW-1){step[1]}}, step});
    if (sum > ACCUM_MAX)      sat = ACCUM_MAX;
    else if (sum < ACCUM_MIN) sat = ACCUM_MIN;
    else                      sat = sum;

    det_u = (cfg.detent_steps == '0) ? DetentW'(1) : cfg.detent_steps;
    det   = $signed({{(AccumW+1-DetentW){1'b0}}, det_u});

    // time passes on every item, rotation or not
    hold_tick = (key_down && item.ms_tick && hold_count != '1)
              ? hold_count + HoldW'(1) : hold_count;

    prev_ab_next     = cur_ab;
    step_accum_next  = sat[AccumW-1:0];
    key_down_next    = key_down;
    hold_count_next  = hold_tick;
    long_fired_next  = long_fired;
    reset_fired_next = reset_fired;
    ev               = EV_NONE;

    if (sat >= det) begin
      step_accum_next = AccumW'(sat - det);
      ev = EV_CW;
    end else if (sat <= -det) begin
      step_accum_next = AccumW'(sat + det);
      ev = EV_CCW;
    end else if (pressed && !key_down) begin
      key_down_next    = 1'b1;
      hold_count_next  = '0;
      long_fired_next  = 1'b0;
      reset_fired_next = 1'b0;
    end else if (pressed) begin
      if (!long_fired && hold_tick >= cfg.long_limit) begin
        long_fired_next = 1'b1;
        ev = EV_LONG;
      end else if (long_fired && !reset_fired && hold_tick >= cfg.reset_hold_ms) begin
        reset_fired_next = 1'b1;
        ev = EV_RESET;
      end
    end else if (key_down) begin
      key_down_next   = 1'b0;
      hold_count_next = '0;
      if (!long_fired && hold_tick < cfg.long_limit) ev = EV_SHORT;
    end

    result.event_res = ev;
    result.hold_ms   = key_down_next ? hold_count_next : '0;
    status.key_down   = key_down;
    status.step_accum = step_accum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab     <= AB_IDLE;
      step_accum  <= '0;
      key_down    <= 1'b0;
      hold_count  <= '0;
      long_fired  <= 1'b0;
      reset_fired <= 1'b0;
    end else if (go) begin
      prev_ab     <= prev_ab_next;
      step_accum  <= step_accum_next;
      key_down    <= key_down_next;
      hold_count  <= hold_count_next;
      long_fired  <= long_fired_next;
      reset_fired <= reset_fired_next;
    end
  end

endmodule

FILE: src/quadrature_knob_event_decoder_unit.sv
// Top level of the quadrature knob event decoder: input register, decoder
// core, result register. Depends on qked_pkg, qked_cfg, qked_core.
`timescale 1ns / 1ps

// Takes one sample of the knob pins (A, B, active-low key, 1 ms tick) per
// transfer and returns exactly one event per sample, in order: rotation
// (clockwise / counter-clockwise once per detent) wins over the button
// events (short press, long press, reset hold), and every result carries the
// current hold time. Throughput is one sample per clock while the output is
// not stalled; the input register captures a sample at its transfer and the
// result register is loaded from the core once the output is free, which
// raises out_valid. The decoder state is updated combinationally in the core
// and registered as each sample is taken, so consecutive samples never wait
// on each other. A result that is stalled at the output holds one more sample
// in the input register before in_stall rises. Configuration writes apply on
// the next clock and must only be issued while no sample is in flight.
module quadrature_knob_event_decoder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qked_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qked_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [qked_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [qked_pkg::CfgW-1:0]     cfg_data
);
  import qked_pkg::*;

  cfg_t         cfg;
  logic         s1_valid;
  in_item_t     s1_data;
  logic         out_free;
  logic         go;
  out_item_t    result;
  core_status_t status;

  assign out_free = !out_valid || !out_stall;
  assign go       = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  qked_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qked_core u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (s1_data),
    .cfg    (cfg),
    .result (result),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_data <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_data <= result;
  end

  // accumulator never reaches the unsaturated negative extreme
  a_accum_range: assert property (@(posedge clk) disable iff (rst)
    status.step_accum != -8'sd128)
    else $error("step accumulator out of range");

  // a sample waiting behind a stalled result is not dropped
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> s1_valid)
    else $error("input stage lost a sample");

  a_long_threshold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == EV_LONG) |->
      (out_data.hold_ms >= cfg.long_limit))
    else $error("long press below threshold");

  a_short_released: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res == EV_SHORT) |->
      (out_data.hold_ms == '0 && !status.key_down))
    else $error("short press while held");

endmodule

FILE: dv/quadrature_knob_event_decoder_unit_tb.sv
// Self-checking testbench for quadrature_knob_event_decoder_unit. A queue-fed
// driver, a stalling receiver and a per-sample knob model check each
// result in order. Depends on qked_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module quadrature_knob_event_decoder_unit_tb;
  import qked_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLDOFF_CYCLES  = 300;
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int RANDOM_PER_SET  = 64;
  localparam int LONG_HOLD_ITEMS = 30;

  // idle styles shared by sender and receiver
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_SHORT = 1;
  localparam int IDLE_MIXED = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  quadrature_knob_event_decoder_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  in_item_t  pending_samples[$];
  out_item_t expected_events[$];

  int idle_mode = IDLE_MIXED;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int tx_gap = 0;
  int rx_wait = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int samples_in = 0;
  int results_checked = 0;
  int settings_used = 1;
  int queued_total = 0;
  int event_tally[6] = '{default: 0};

  // knob model state and its copy of the registers
  logic [15:0] long_cfg = 16'd800;
  logic [15:0] reset_cfg = 16'd5000;
  logic [2:0]  detent_cfg = 3'd2;
  logic [1:0]  ab_last = 2'b11;
  int          step_sum = 0;
  logic        key_held = 1'b0;
  logic [15:0] hold_cnt = '0;
  logic        long_done = 1'b0;
  logic        reset_done = 1'b0;

  // stimulus generator view of the pins
  logic [1:0] gen_ab = 2'b11;
  logic       gen_key = 1'b1;

  // 2-bit Gray code <-> position along the rotation; the map is its own inverse
  function automatic logic [1:0] gray_flip(logic [1:0] v);
    return {v[1], v[1] ^ v[0]};
  endfunction

  function automatic int pick_len(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == IDLE_NONE) return 0;
    if (roll < 60) return 0;
    if (mode == IDLE_SHORT || roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic out_item_t knob_predict(in_item_t s);
    logic [1:0] cur_ab;
    logic [1:0] moved;
    logic pressed;
    int det;
    out_item_t res;
    cur_ab = {s.pin_a, s.pin_b};
    moved = gray_flip(cur_ab) - gray_flip(ab_last);
    pressed = ~s.key_level;
    det = (detent_cfg == 3'd0) ? 1 : int'(detent_cfg);
    res.event_res = EV_NONE;

    if (moved == 2'd1) step_sum++;
    else if (moved == 2'd3) step_sum--;
    if (step_sum > 127) step_sum = 127;
    if (step_sum < -127) step_sum = -127;
    ab_last = cur_ab;

    // time runs on even when a rotation wins this sample
    if (key_held && s.ms_tick && hold_cnt != 16'hFFFF) hold_cnt++;

    if (step_sum >= det) begin
      step_sum -= det;
      res.event_res = EV_CW;
    end else if (step_sum <= -det) begin
      step_sum += det;
      res.event_res = EV_CCW;
    end else if (pressed && !key_held) begin
      key_held = 1'b1;
      hold_cnt = '0;
      long_done = 1'b0;
      reset_done = 1'b0;
    end else if (pressed) begin
      if (!long_done && hold_cnt >= long_cfg) begin
        long_done = 1'b1;
        res.event_res = EV_LONG;
      end else if (long_done && !reset_done && hold_cnt >= reset_cfg) begin
        reset_done = 1'b1;
        res.event_res = EV_RESET;
      end
    end else if (key_held) begin
      key_held = 1'b0;
      if (!long_done && hold_cnt < long_cfg) res.event_res = EV_SHORT;
      hold_cnt = '0;
    end

    res.hold_ms = key_held ? hold_cnt : '0;
    return res;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // payload held until the transfer
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      in_data <= pending_samples.pop_front();
      in_valid <= 1'b1;
      tx_gap = pick_len(idle_mode);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_req != holdoff_seen) begin
      holdoff_seen++;
      rx_wait = HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      rx_wait = pick_len(idle_mode);
      out_stall <= (rx_wait > 0);
      if (rx_wait > 0) rx_wait--;
    end
  end

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && in_valid && !in_stall) begin
      expected_events.push_back(knob_predict(in_data));
      samples_in++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result: event_res %0d, hold_ms %0d",
               out_data.event_res, out_data.hold_ms);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        results_checked++;
        if (out_data.event_res !== want.event_res) begin
          $error("event_res mismatch: expected %0d, actual %0d",
                 want.event_res, out_data.event_res);
          mismatches++;
        end
        if (out_data.hold_ms !== want.hold_ms) begin
          $error("hold_ms mismatch: expected %0d, actual %0d",
                 want.hold_ms, out_data.hold_ms);
          mismatches++;
        end
        if (int'(want.event_res) < 6) event_tally[int'(want.event_res)]++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_events.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic offer(logic [1:0] ab, logic key, logic tick);
    in_item_t s;
    s.pin_a = ab[1];
    s.pin_b = ab[0];
    s.key_level = key;
    s.ms_tick = tick;
    pending_samples.push_back(s);
    queued_total++;
    gen_ab = ab;
    gen_key = key;
  endtask

  // dir +1 is clockwise
  task automatic turn(int dir, int n);
    logic [1:0] p;
    repeat (n) begin
      p = gray_flip(gen_ab) + dir[1:0];
      offer(gray_flip(p), gen_key, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic hold_key(int n, int tick_pct);
    repeat (n) offer(gen_ab, 1'b0, $urandom_range(0, 99) < tick_pct);
  endtask

  task automatic shuffle_knob(int count);
    int start;
    int kind;
    int len;
    start = queued_total;
    while (queued_total - start < count) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(1, 8);
      if (kind < 4) begin
        turn($urandom_range(0, 1) ? 1 : -1, len);
      end else if (kind < 7) begin
        hold_key($urandom_range(1, 14), 80);
        if ($urandom_range(0, 2) == 0) turn($urandom_range(0, 1) ? 1 : -1, $urandom_range(1, 3));
        hold_key($urandom_range(0, 6), 80);
        offer(gen_ab, 1'b1, 1'($urandom_range(0, 1)));
      end else if (kind == 7) begin
        // contact bounce
        repeat (len) begin
          turn(1, 1);
          turn(-1, 1);
        end
      end else begin
        repeat (len) offer(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic [15:0] long_v, logic [15:0] reset_v, logic [15:0] det_v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LONG_PRESS;
    cfg_data <= long_v;
    @(posedge clk);
    cfg_index <= CFG_RESET_HOLD;
    cfg_data <= reset_v;
    @(posedge clk);
    cfg_index <= CFG_DETENT;
    cfg_data <= det_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    long_cfg = long_v;
    reset_cfg = reset_v;
    detent_cfg = det_v[2:0];
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults: rotation both ways, invalid jumps, bounce, short press
    offer(2'b11, 1'b1, 1'b0);
    turn(1, 4);
    turn(-1, 4);
    turn(2, 2);
    turn(1, 1);
    turn(-1, 1);
    hold_key(3, 100);
    offer(gen_ab, 1'b1, 1'b1);
    wait_drained();

    // low thresholds: long press, reset hold, rotation in mid-hold, quiet release
    configure(16'd3, 16'd6, 16'd1);
    hold_key(5, 100);
    turn(1, 1);
    hold_key(4, 100);
    offer(gen_ab, 1'b1, 1'b1);
    shuffle_knob(RANDOM_PER_SET);
    wait_drained();

    // zero thresholds and zero detent
    idle_mode = IDLE_SHORT;
    configure(16'd0, 16'd0, 16'd0);
    shuffle_knob(RANDOM_PER_SET);
    wait_drained();

    // reset threshold under the long one, widest legal detent
    idle_mode = IDLE_MIXED;
    configure(16'd5, 16'd2, 16'd7);
    shuffle_knob(RANDOM_PER_SET);
    wait_drained();

    // sender floods while the receiver holds off
    idle_mode = IDLE_NONE;
    configure(16'd1, 16'd1, 16'd5);
    shuffle_knob(RANDOM_PER_SET);
    holdoff_req++;
    wait_drained();

    // top thresholds: a long hold that never reaches the long press
    idle_mode = IDLE_SHORT;
    configure(16'hFFFF, 16'hFFFF, 16'd4);
    hold_key(LONG_HOLD_ITEMS, 100);
    offer(gen_ab, 1'b1, 1'b1);
    wait_drained();

    idle_mode = IDLE_MIXED;
    configure(16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)),
              16'($urandom_range(0, 7)));
    shuffle_knob(RANDOM_PER_SET);
    wait_drained();

    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      mismatches++;
    end

    $display("Covered %0d samples, %0d results checked, %0d register settings.",
             samples_in, results_checked, settings_used);
    $display("Events seen: none %0d, cw %0d, ccw %0d, short %0d, long %0d, reset %0d.",
             event_tally[EV_NONE], event_tally[EV_CW], event_tally[EV_CCW],
             event_tally[EV_SHORT], event_tally[EV_LONG], event_tally[EV_RESET]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
